>>> design/csc_pkg.sv
// shared types, constants and helpers for the color space converter
package csc_pkg;

  localparam int ChBits  = 8;
  localparam int HueBits = 11;
  localparam logic [ChBits-1:0] ChMax = '1;
  localparam logic [HueBits-1:0] HueRange = 11'd1536;

  typedef enum logic [2:0] {
    MODE_HSV2RGB  = 3'd0,
    MODE_RGB2HSV  = 3'd1,
    MODE_CMYK2RGB = 3'd2,
    MODE_RGB2CMYK = 3'd3,
    MODE_HSV2CMYK = 3'd4,
    MODE_CMYK2HSV = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0]  in_alpha;
    logic [10:0] in_first;
    logic [7:0]  in_second;
    logic [7:0]  in_third;
    logic [7:0]  in_fourth;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_alpha;
    logic [10:0] out_first;
    logic [7:0]  out_second;
    logic [7:0]  out_third;
    logic [7:0]  out_fourth;
  } pix_out_t;

  // floor(x / 255) for x < 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] q;
    q = ({1'b0, x} + 17'd1 + {9'd0, x[15:8]}) >> 8;
    return q[7:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [10:0] x);
    return (x > 11'd255) ? 8'hff : x[7:0];
  endfunction

endpackage

>>> design/color_space_converter.sv
// top level of the pixel color space converter
//
//  channel  | signals                          | timing
//  ---------+----------------------------------+----------------------------
//  config   | cfg_we, cfg_data                 | written on any edge with we
//  request  | start, busy, in_pix              | taken when start && !busy
//  result   | done, out_pix                    | one cycle, cannot be held
//
// one pixel per clock; done rises after the request passes the input register,
// the rgb register, 19 divider stages (hue, saturation and cyan/magenta/yellow
// dividers run side by side) and the output register
// busy is always low: nothing inside can stall
// synchronous reset clears the mode and all valid bits
module color_space_converter import csc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [2:0] cfg_data,
  input  logic     start,
  output logic     busy,
  input  pix_in_t  in_pix,
  output logic     done,
  output pix_out_t out_pix
);
  localparam int DivLat = 19;
  // stages: a (sat/mult) b (hsv->rgb) c (prep) div d (finish) e (out)

  logic [2:0] mode;
  always_ff @(posedge clk) begin
    if (rst) mode <= '0;
    else if (cfg_we) mode <= cfg_data;
  end
  assign busy = 1'b0;

  // ---- stage a: register inputs with the hue wrapped, hsv products
  logic a_v;
  logic [2:0] a_mode;
  logic [7:0] a_alpha, a_v8, a_p2, a_p3, a_k;
  logic [10:0] a_h, a_p1;
  logic [15:0] a_vs, a_vm;   // v*s, v*(M-s)
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else a_v <= start;
    a_mode  <= mode;
    a_alpha <= in_pix.in_alpha;
    a_h     <= (in_pix.in_first >= HueRange) ? 11'(in_pix.in_first - HueRange)
                                              : in_pix.in_first;
    a_p1    <= in_pix.in_first;
    a_v8    <= in_pix.in_third;
    a_p2    <= in_pix.in_second;
    a_p3    <= in_pix.in_third;
    a_k     <= in_pix.in_fourth;
    a_vm    <= 16'(in_pix.in_third * (ChMax - in_pix.in_second));
    a_vs    <= 16'(in_pix.in_third * in_pix.in_second);
  end

  // ---- stage b: hsv->rgb, cmyk->rgb or clipped rgb, giving intermediate rgb
  logic [23:0] part;
  logic [7:0] low, rise, fall;
  logic [31:0] risen, falln;
  logic [7:0] hr, hg, hb, cr, cg, cb, kinv;
  always_comb begin
    part  = 24'(a_h[7:0] * a_vs);
    low   = div255(a_vm);
    risen = {8'd0, a_vm, 8'd0} + {8'd0, part};
    falln = {8'd0, 16'(a_v8 * ChMax), 8'd0} - {8'd0, part};
    rise  = div255(risen[23:8]);
    fall  = div255(falln[23:8]);
    // risen/(255*256) = floor(floor(risen/256)/255)
    case (a_h[10:8])
      3'd0: begin hr = a_v8; hg = rise; hb = low;  end
      3'd1: begin hr = fall; hg = a_v8; hb = low;  end
      3'd2: begin hr = low;  hg = a_v8; hb = rise; end
      3'd3: begin hr = low;  hg = fall; hb = a_v8; end
      3'd4: begin hr = rise; hg = low;  hb = a_v8; end
      default: begin hr = a_v8; hg = low; hb = fall; end
    endcase
    kinv = ChMax - a_k;
    cr = div255(16'((ChMax - sat8(a_p1)) * kinv));
    cg = div255(16'((ChMax - a_p2) * kinv));
    cb = div255(16'((ChMax - a_p3) * kinv));
  end

  logic b_v;
  logic [2:0] b_mode;
  logic [7:0] b_alpha, b_r, b_g, b_b;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else b_v <= a_v;
    b_mode  <= a_mode;
    b_alpha <= a_alpha;
    case (a_mode)
      MODE_HSV2RGB, MODE_HSV2CMYK: begin b_r <= hr; b_g <= hg; b_b <= hb; end
      MODE_CMYK2RGB, MODE_CMYK2HSV: begin b_r <= cr; b_g <= cg; b_b <= cb; end
      default: begin b_r <= sat8(a_p1); b_g <= a_p2; b_b <= a_p3; end
    endcase
  end

  // ---- stage c: max/min and divider operands
  logic [7:0] mx, mn, dl, ck, cc, cm, cy, kden, hdiff;
  logic [18:0] hnum;
  logic [10:0] hbase;
  logic sub_h;   // fraction subtracts from the sector base
  always_comb begin
    mx = b_r; if (b_g > mx) mx = b_g; if (b_b > mx) mx = b_b;
    mn = b_r; if (b_g < mn) mn = b_g; if (b_b < mn) mn = b_b;
    dl = mx - mn;
    if (mx == b_r) begin
      sub_h = !(b_g >= b_b);
      hbase = sub_h ? 11'd1536 : 11'd0;
      hdiff = sub_h ? 8'(b_b - b_g) : 8'(b_g - b_b);
    end else if (mx == b_g) begin
      sub_h = !(b_b >= b_r);
      hbase = 11'd512;
      hdiff = sub_h ? 8'(b_r - b_b) : 8'(b_b - b_r);
    end else begin
      sub_h = !(b_r >= b_g);
      hbase = 11'd1024;
      hdiff = sub_h ? 8'(b_g - b_r) : 8'(b_r - b_g);
    end
    // a subtracted fraction is rounded up so the folded hue still truncates
    hnum = {3'd0, hdiff, 8'd0} + (sub_h ? {11'd0, 8'(dl - 8'd1)} : 19'd0);
    cc = ChMax - b_r; cm = ChMax - b_g; cy = ChMax - b_b;
    ck = ChMax - mx;
    kden = mx;
  end

  logic [18:0] q_h, q_s, q_c, q_m, q_y;
  logic [7:0] den_c;
  assign den_c = (kden == 8'd0) ? 8'd1 : kden;
  csc_div u_div_h (.clk, .num(hnum), .den((dl == 0) ? 8'd1 : dl), .quo(q_h));
  csc_div u_div_s (.clk, .num({3'd0, 16'(dl * ChMax)}), .den((mx == 0) ? 8'd1 : mx),
                   .quo(q_s));
  csc_div u_div_c (.clk, .num({3'd0, 16'((cc - ck) * ChMax)}), .den(den_c), .quo(q_c));
  csc_div u_div_m (.clk, .num({3'd0, 16'((cm - ck) * ChMax)}), .den(den_c), .quo(q_m));
  csc_div u_div_y (.clk, .num({3'd0, 16'((cy - ck) * ChMax)}), .den(den_c), .quo(q_y));

  // side data delayed alongside the dividers
  typedef struct packed {
    logic       v;
    logic [2:0] mode;
    logic [7:0] alpha;
    logic [7:0] mx;
    logic       dz;
    logic       sub;
    logic [10:0] base;
    logic [7:0] k;
  } side_t;
  side_t sd [DivLat+1];
  always_comb begin
    sd[0] = '{v: b_v, mode: b_mode, alpha: b_alpha, mx: mx, dz: (dl == 0),
              sub: sub_h, base: hbase, k: ck};
  end
  for (genvar i = 0; i < DivLat; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (rst) sd[i+1] <= '0;
      else sd[i+1] <= sd[i];
    end
  end

  // rgb results are delayed with the divider so every mode has the same latency
  logic [23:0] rgbd [DivLat+1];
  assign rgbd[0] = {b_r, b_g, b_b};
  for (genvar i = 0; i < DivLat; i++) begin : g_rgb
    always_ff @(posedge clk) rgbd[i+1] <= rgbd[i];
  end

  // ---- finish: hue fold and output select
  side_t e;
  logic [11:0] hue;
  pix_out_t res;
  assign e = sd[DivLat];
  always_comb begin
    hue = e.sub ? 12'({1'b0, e.base} - 12'(q_h)) : 12'({1'b0, e.base} + 12'(q_h));
    if (hue >= 12'd1536) hue = 12'(hue - 12'd1536);
    if (e.dz) hue = '0;
    res = '0;
    res.out_alpha = e.alpha;
    case (e.mode)
      MODE_HSV2RGB, MODE_CMYK2RGB: begin
        // rgb modes take the delayed intermediate rgb
        res.out_first  = {3'd0, rgbd[DivLat][23:16]};
        res.out_second = rgbd[DivLat][15:8];
        res.out_third  = rgbd[DivLat][7:0];
      end
      MODE_RGB2HSV, MODE_CMYK2HSV: begin
        res.out_first  = hue[10:0];
        res.out_second = (e.mx == 0) ? 8'd0 : q_s[7:0];
        res.out_third  = e.mx;
      end
      MODE_RGB2CMYK, MODE_HSV2CMYK: begin
        if (e.k != ChMax) begin
          res.out_first  = {3'd0, q_c[7:0]};
          res.out_second = q_m[7:0];
          res.out_third  = q_y[7:0];
        end
        res.out_fourth = e.k;
      end
      default: res = '{out_alpha: e.alpha, default: '0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= e.v;
    out_pix <= res;
  end

  // ---- checks
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, DivLat + 3))
    else $error("result without request");
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> out_pix.out_first < HueRange)
    else $error("hue out of range");
endmodule

>>> design/csc_div.sv
// pipelined restoring divider, one quotient bit per stage
module csc_div import csc_pkg::*; (
  input  logic        clk,
  input  logic [18:0] num,
  input  logic [7:0]  den,
  output logic [18:0] quo
);
  // stage i holds partial remainder and quotient after i bits
  logic [18:0] n_q [20];
  logic [8:0]  r_q [20];
  logic [7:0]  d_q [20];

  always_comb begin
    n_q[0] = num;
    r_q[0] = '0;
    d_q[0] = den;
  end

  for (genvar i = 0; i < 19; i++) begin : g_st
    logic [9:0]  rs;
    logic [18:0] nn;
    logic [8:0]  rn;
    always_comb begin
      rs = {r_q[i], n_q[i][18]};
      nn = {n_q[i][17:0], 1'b0};
      if (rs >= {2'b0, d_q[i]}) begin
        rn = 9'(rs - {2'b0, d_q[i]});
        nn[0] = 1'b1;
      end else begin
        rn = rs[8:0];
      end
    end
    always_ff @(posedge clk) begin
      n_q[i+1] <= nn;
      r_q[i+1] <= rn;
      d_q[i+1] <= d_q[i];
    end
  end

  assign quo = n_q[19];
endmodule

>>> test/tb.sv
// self-checking testbench for the pixel color space converter
`timescale 1ns / 100ps

module tb;
  import csc_pkg::*;

  // one directed stimulus row: mode, pixel and optional typed-in result
  typedef struct {
    logic [2:0] mode;
    pix_in_t    pix;
    bit         typed;
    pix_out_t   want;
  } dir_row_t;

  localparam longint unsigned M   = 255;
  localparam longint unsigned SEC = 256;
  localparam longint unsigned HR  = 1536;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_data = 3'd0;
  logic       start = 1'b0;
  logic       busy;
  pix_in_t    in_pix = '0;
  logic       done;
  pix_out_t   out_pix;

  // conversion currently programmed into the block
  logic [2:0] cur_mode;
  // pixels the block still owes, oldest first
  pix_out_t   owed_pix[$];
  int         errors = 0;
  bit         may_idle = 1'b1;

  color_space_converter u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .in_pix(in_pix), .done(done), .out_pix(out_pix)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned clip(longint unsigned x);
    return (x > M) ? M : x;
  endfunction

  // hsv with 1536-step hue to 8-bit rgb, truncating
  function automatic void hsv_rgb(longint unsigned h, longint unsigned s,
                                  longint unsigned v, output longint unsigned c[3]);
    longint unsigned sec, fr, prod, lo, up, dn;
    h = h % HR;
    s = clip(s);
    v = clip(v);
    sec = h / SEC;
    fr = h % SEC;
    prod = fr * s * v;
    lo = v * (M - s) / M;
    up = (v * (M - s) * SEC + prod) / (M * SEC);
    dn = (v * M * SEC - prod) / (M * SEC);
    case (sec)
      0: c = '{v, up, lo};
      1: c = '{dn, v, lo};
      2: c = '{lo, v, up};
      3: c = '{lo, dn, v};
      4: c = '{up, lo, v};
      default: c = '{v, lo, dn};
    endcase
  endfunction

  // rgb to hsv; red wins hue ties, then green
  function automatic void rgb_hsv(longint unsigned r, longint unsigned g,
                                  longint unsigned b, output longint unsigned c[3]);
    longint unsigned mx, mn, dl, num, hue, sv;
    r = clip(r); g = clip(g); b = clip(b);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    dl = mx - mn;
    hue = 0;
    sv = (mx != 0) ? dl * M / mx : 0;
    if (dl != 0) begin
      if (mx == r) begin
        num = (g >= b) ? (g - b) * SEC : 6 * dl * SEC - (b - g) * SEC;
      end else if (mx == g) begin
        num = (b >= r) ? 2 * dl * SEC + (b - r) * SEC : 2 * dl * SEC - (r - b) * SEC;
      end else begin
        num = (r >= g) ? 4 * dl * SEC + (r - g) * SEC : 4 * dl * SEC - (g - r) * SEC;
      end
      hue = num / dl;
      if (hue >= HR) hue -= HR;
    end
    c = '{hue, sv, mx};
  endfunction

  function automatic void cmyk_rgb(longint unsigned cy, longint unsigned mg,
                                   longint unsigned ye, longint unsigned k,
                                   output longint unsigned c[3]);
    longint unsigned ki;
    ki = M - clip(k);
    c = '{(M - clip(cy)) * ki / M, (M - clip(mg)) * ki / M, (M - clip(ye)) * ki / M};
  endfunction

  // full black forces cyan, magenta and yellow to zero
  function automatic void rgb_cmyk(longint unsigned r, longint unsigned g,
                                   longint unsigned b, output longint unsigned c[4]);
    longint unsigned cy, mg, ye, k;
    cy = M - clip(r); mg = M - clip(g); ye = M - clip(b);
    k = cy; if (mg < k) k = mg; if (ye < k) k = ye;
    if (k < M) c = '{(cy - k) * M / (M - k), (mg - k) * M / (M - k), (ye - k) * M / (M - k), k};
    else c = '{0, 0, 0, k};
  endfunction

  // expected converted pixel for the current mode
  function automatic pix_out_t convert_pix(logic [2:0] mode, pix_in_t p);
    longint unsigned t[3], r3[3], r4[4];
    pix_out_t o;
    r4 = '{0, 0, 0, 0};
    case (mode)
      MODE_HSV2RGB: begin
        hsv_rgb(p.in_first, p.in_second, p.in_third, r3);
        r4 = '{r3[0], r3[1], r3[2], 0};
      end
      MODE_RGB2HSV: begin
        rgb_hsv(p.in_first, p.in_second, p.in_third, r3);
        r4 = '{r3[0], r3[1], r3[2], 0};
      end
      MODE_CMYK2RGB: begin
        cmyk_rgb(p.in_first, p.in_second, p.in_third, p.in_fourth, r3);
        r4 = '{r3[0], r3[1], r3[2], 0};
      end
      MODE_RGB2CMYK: rgb_cmyk(p.in_first, p.in_second, p.in_third, r4);
      MODE_HSV2CMYK: begin
        hsv_rgb(p.in_first, p.in_second, p.in_third, t);
        rgb_cmyk(t[0], t[1], t[2], r4);
      end
      MODE_CMYK2HSV: begin
        cmyk_rgb(p.in_first, p.in_second, p.in_third, p.in_fourth, t);
        rgb_hsv(t[0], t[1], t[2], r3);
        r4 = '{r3[0], r3[1], r3[2], 0};
      end
      default: ;  // unused modes give zero channels
    endcase
    o.out_alpha  = p.in_alpha;
    o.out_first  = r4[0][10:0];
    o.out_second = r4[1][7:0];
    o.out_third  = r4[2][7:0];
    o.out_fourth = r4[3][7:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // result side: done is held one cycle only, so sample mid-cycle
  always @(negedge clk) begin
    pix_out_t w;
    if (!rst && done) begin
      if (owed_pix.size() == 0) begin
        report_mismatch("unrequested result", 1, 0);
      end else begin
        w = owed_pix.pop_front();
        if (out_pix.out_alpha != w.out_alpha)
          report_mismatch("alpha", out_pix.out_alpha, w.out_alpha);
        if (out_pix.out_first != w.out_first)
          report_mismatch("first", out_pix.out_first, w.out_first);
        if (out_pix.out_second != w.out_second)
          report_mismatch("second", out_pix.out_second, w.out_second);
        if (out_pix.out_third != w.out_third)
          report_mismatch("third", out_pix.out_third, w.out_third);
        if (out_pix.out_fourth != w.out_fourth)
          report_mismatch("fourth", out_pix.out_fourth, w.out_fourth);
      end
    end
  end

  // drain the pipe, settle, then program a new mode
  task automatic set_mode(logic [2:0] m);
    start <= 1'b0;
    @(posedge clk);
    while (owed_pix.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = m;
  endtask

  // issue one request; start stays high when requests come back to back
  task automatic send_pix(pix_in_t p, bit typed, pix_out_t want);
    bit ok;
    if (may_idle && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_pix <= p;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    owed_pix.push_back(typed ? want : convert_pix(cur_mode, p));
  endtask

  function automatic logic [7:0] rand_ch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic pix_in_t rand_pix(logic [2:0] m);
    pix_in_t p;
    int r;
    p.in_alpha  = 8'($urandom);
    p.in_second = rand_ch();
    p.in_third  = rand_ch();
    p.in_fourth = rand_ch();
    r = $urandom_range(0, 99);
    if (r < 10) p.in_first = 11'($urandom);  // wrapped hue or clipped channel
    else if (m == MODE_HSV2RGB || m == MODE_HSV2CMYK) p.in_first = 11'($urandom_range(0, 1535));
    else p.in_first = {3'd0, rand_ch()};
    // grey pixels exercise the zero hue and tie paths
    if ($urandom_range(0, 9) == 0) begin
      p.in_second = p.in_first[7:0];
      p.in_third  = p.in_first[7:0];
    end
    return p;
  endfunction

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(logic [2:0] m, logic [10:0] a, logic [7:0] b,
                                   logic [7:0] c, logic [7:0] k, logic [7:0] al,
                                   bit typed, pix_out_t want);
    dir_row_t d;
    d.mode = m;
    d.pix = '{al, a, b, c, k};
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  initial begin
    pix_out_t z;
    logic [2:0] m;
    z = '0;
    cur_mode = MODE_HSV2RGB;
    // reset mode is hsv to rgb: pure white and black need no write
    dir_rows.push_back(row(MODE_HSV2RGB, 11'd0, 8'd0, 8'd255, 8'd0, 8'd255, 1,
                           '{8'd255, 11'd255, 8'd255, 8'd255, 8'd0}));
    dir_rows.push_back(row(MODE_HSV2RGB, 11'd1535, 8'd255, 8'd0, 8'd255, 8'd0, 1,
                           '{8'd0, 11'd0, 8'd0, 8'd0, 8'd0}));
    dir_rows.push_back(row(MODE_HSV2RGB, 11'd0, 8'd255, 8'd255, 8'd0, 8'd7, 1,
                           '{8'd7, 11'd255, 8'd0, 8'd0, 8'd0}));
    dir_rows.push_back(row(MODE_HSV2RGB, 11'd2047, 8'd200, 8'd180, 8'd9, 8'd1, 0, z));
    dir_rows.push_back(row(MODE_HSV2RGB, 11'd767, 8'd255, 8'd255, 8'd0, 8'd2, 0, z));
    // black and grey rgb give zero hue
    dir_rows.push_back(row(MODE_RGB2HSV, 11'd0, 8'd0, 8'd0, 8'd0, 8'd3, 1,
                           '{8'd3, 11'd0, 8'd0, 8'd0, 8'd0}));
    dir_rows.push_back(row(MODE_RGB2HSV, 11'd128, 8'd128, 8'd128, 8'd0, 8'd4, 1,
                           '{8'd4, 11'd0, 8'd0, 8'd128, 8'd0}));
    dir_rows.push_back(row(MODE_RGB2HSV, 11'd255, 8'd0, 8'd0, 8'd0, 8'd5, 1,
                           '{8'd5, 11'd0, 8'd255, 8'd255, 8'd0}));
    dir_rows.push_back(row(MODE_RGB2HSV, 11'd2047, 8'd255, 8'd0, 8'd0, 8'd6, 0, z));
    dir_rows.push_back(row(MODE_RGB2HSV, 11'd10, 8'd200, 8'd200, 8'd0, 8'd6, 0, z));
    dir_rows.push_back(row(MODE_RGB2HSV, 11'd0, 8'd1, 8'd255, 8'd0, 8'd6, 0, z));
    // cmyk with full black and with no ink
    dir_rows.push_back(row(MODE_CMYK2RGB, 11'd0, 8'd0, 8'd0, 8'd255, 8'd8, 1,
                           '{8'd8, 11'd0, 8'd0, 8'd0, 8'd0}));
    dir_rows.push_back(row(MODE_CMYK2RGB, 11'd0, 8'd0, 8'd0, 8'd0, 8'd9, 1,
                           '{8'd9, 11'd255, 8'd255, 8'd255, 8'd0}));
    dir_rows.push_back(row(MODE_CMYK2RGB, 11'd2047, 8'd17, 8'd99, 8'd40, 8'd9, 0, z));
    dir_rows.push_back(row(MODE_RGB2CMYK, 11'd0, 8'd0, 8'd0, 8'd0, 8'd10, 1,
                           '{8'd10, 11'd0, 8'd0, 8'd0, 8'd255}));
    dir_rows.push_back(row(MODE_RGB2CMYK, 11'd255, 8'd255, 8'd255, 8'd0, 8'd11, 1,
                           '{8'd11, 11'd0, 8'd0, 8'd0, 8'd0}));
    dir_rows.push_back(row(MODE_RGB2CMYK, 11'd1000, 8'd30, 8'd60, 8'd0, 8'd11, 0, z));
    dir_rows.push_back(row(MODE_HSV2CMYK, 11'd300, 8'd0, 8'd0, 8'd0, 8'd12, 1,
                           '{8'd12, 11'd0, 8'd0, 8'd0, 8'd255}));
    dir_rows.push_back(row(MODE_HSV2CMYK, 11'd1100, 8'd170, 8'd230, 8'd0, 8'd12, 0, z));
    dir_rows.push_back(row(MODE_CMYK2HSV, 11'd40, 8'd40, 8'd40, 8'd255, 8'd13, 1,
                           '{8'd13, 11'd0, 8'd0, 8'd0, 8'd0}));
    dir_rows.push_back(row(MODE_CMYK2HSV, 11'd0, 8'd128, 8'd255, 8'd20, 8'd13, 0, z));
    // modes past the last conversion return zero channels
    dir_rows.push_back(row(3'd6, 11'd2047, 8'd255, 8'd255, 8'd255, 8'd255, 1,
                           '{8'd255, 11'd0, 8'd0, 8'd0, 8'd0}));
    dir_rows.push_back(row(3'd7, 11'd1234, 8'd1, 8'd2, 8'd3, 8'd14, 1,
                           '{8'd14, 11'd0, 8'd0, 8'd0, 8'd0}));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) set_mode(dir_rows[i].mode);
      send_pix(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases walk every mode, the extremes included
    for (int ph = 0; ph < 10; ph++) begin
      m = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      set_mode(m);
      may_idle = (ph != 4);  // one long run of back-to-back requests
      for (int n = 0; n < 148; n++) send_pix(rand_pix(m), 1'b0, z);
    end
    start <= 1'b0;

    @(posedge clk);
    while (owed_pix.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> color_space_converter.f
design/csc_pkg.sv
design/csc_div.sv
design/color_space_converter.sv
test/tb.sv
